/* hw/rtl/stn_lcd_grayscale_scan_controller_macros.svh */
// ----------------------------------------------------------------------------
// STN LCD grayscale scan controller - assertion macros
// Shared property forms for the controller's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STN_LCD_GRAYSCALE_SCAN_CONTROLLER_MACROS_SVH
`define STN_LCD_GRAYSCALE_SCAN_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLGSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("slgsc check failed");

// Next-cycle implication, checked outside reset.
`define SLGSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("slgsc check failed");

`endif

/* hw/rtl/slgsc_pkg.sv */
// ----------------------------------------------------------------------------
// STN LCD grayscale scan controller - package
// Panel geometry, derived widths, plane sequence and pixel-to-plane split.
// ----------------------------------------------------------------------------
package slgsc_pkg;

	localparam int ROWS        = 240;
	localparam int LINE_BYTES  = 40;
	localparam int DUMMY_LINES = 8;

	localparam int STORE_DEPTH = ROWS * LINE_BYTES;
	localparam int SHIFTS      = 2 * LINE_BYTES;
	localparam int FINAL_LINE  = ROWS + DUMMY_LINES;

	localparam int ADDR_W = 14;
	localparam int PIX_W  = 32;
	localparam int MEM_AW = $clog2(STORE_DEPTH);
	localparam int LINE_W = $clog2(FINAL_LINE + 1);
	localparam int EV_W   = $clog2(SHIFTS + 1);

	localparam int SEQ_LEN = 15;
	localparam int SEQ_W   = 4;

	// Frame rate control order: plane 0 eight times, 1 four, 2 twice, 3 once
	localparam logic [1:0] PLANE_SEQ [SEQ_LEN] = '{
		2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd0, 2'd1,
		2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0
	};

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef struct packed {
		logic       latch;
		logic       fr;
		logic [1:0] plane;
		logic       last;
		logic       sel_low;
	} slgsc_meta_t;

	// Pixel p nibble is px[31-4p -: 4]; plane k byte is word[31-8k -: 8],
	// its bit 7-p holding bit 3-k of pixel p.
	function automatic logic [PIX_W-1:0] split_planes(input logic [PIX_W-1:0] px);
		logic [PIX_W-1:0] word;
		word = '0;
		for (int k = 0; k < 4; k++) begin
			for (int p = 0; p < 8; p++) begin
				word[31 - 8 * k - p] = px[31 - 4 * p - k];
			end
		end
		return word;
	endfunction

endpackage

/* hw/rtl/stn_lcd_grayscale_scan_controller.sv */
// A tick's panel event is registered in s1, then in s2; writes give no output.
// Throughput: one transaction per cycle, write or tick, unless the output stalls.
// The image store has one write and one registered read port; each tick reads it once.
// Reset (arst_n low) clears line, event and sequence counters and the pipeline valids.
// The image store is not cleared; load the image before the first tick.
// ----------------------------------------------------------------------------
// STN LCD grayscale scan controller
// Stores bit-plane image data and produces shift/latch panel events for
// frame rate control grayscale over four bit planes.
// ----------------------------------------------------------------------------
`include "stn_lcd_grayscale_scan_controller_macros.svh"

module stn_lcd_grayscale_scan_controller
	import slgsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [13:0] column_address, [45:14] packed_pixels, [47:46] zero
	input  logic [47:0] s_axis_tdata,
	// [0] kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] data_nibble, [4] frame_signal, [6:5] plane_shown, [7] zero
	output logic [7:0]  m_axis_tdata,
	// [0] is_latch
	output logic        m_axis_tuser,
	// frame_last
	output logic        m_axis_tlast
);

	localparam logic [LINE_W-1:0] LAST_ROW   = LINE_W'(ROWS - 1);
	localparam logic [LINE_W-1:0] ROWS_L     = LINE_W'(ROWS);
	localparam logic [LINE_W-1:0] FINAL_L    = LINE_W'(FINAL_LINE);
	localparam logic [EV_W-1:0]   SHIFTS_E   = EV_W'(SHIFTS);
	localparam logic [SEQ_W-1:0]  SEQ_LAST   = SEQ_W'(SEQ_LEN - 1);
	localparam logic [ADDR_W:0]   DEPTH_A    = (ADDR_W + 1)'(STORE_DEPTH);
	localparam logic [MEM_AW-1:0] LINE_BYTES_M = MEM_AW'(LINE_BYTES);

	logic [PIX_W-1:0] mem [STORE_DEPTH];

	logic [LINE_W-1:0] line_q;
	logic [EV_W-1:0]   ev_q;
	logic [SEQ_W-1:0]  seq_q;

	logic              v_s1;
	slgsc_meta_t       meta_s1;
	logic [PIX_W-1:0]  rdata_s1;

	logic              v_s2;
	logic [3:0]        nib_s2;
	slgsc_meta_t       meta_s2;

	logic              adv;
	logic              acc;
	logic              acc_tick;
	logic              acc_write;
	logic [ADDR_W-1:0] wr_addr;
	logic [PIX_W-1:0]  wr_px;
	logic [LINE_W-1:0] row_sel;
	logic [MEM_AW-1:0] rd_addr;
	slgsc_meta_t       meta_d;
	logic [7:0]        plane_byte;

	assign adv           = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign acc_tick      = acc && (s_axis_tuser == KIND_TICK);
	assign acc_write     = acc && (s_axis_tuser == KIND_WRITE);
	assign wr_addr       = s_axis_tdata[ADDR_W-1:0];
	assign wr_px         = s_axis_tdata[ADDR_W +: PIX_W];

	// Dummy lines repeat the last image row
	assign row_sel = (line_q < ROWS_L) ? line_q : LAST_ROW;
	assign rd_addr = MEM_AW'(row_sel) * LINE_BYTES_M + MEM_AW'(ev_q[EV_W-1:1]);

	always_comb begin
		meta_d.fr      = (line_q == '0);
		meta_d.plane   = PLANE_SEQ[seq_q];
		meta_d.latch   = (line_q >= FINAL_L) || (ev_q >= SHIFTS_E);
		meta_d.last    = (line_q >= FINAL_L);
		meta_d.sel_low = (line_q < ROWS_L) && ev_q[0];
	end

	// Image store
	always_ff @(posedge clk) begin
		if (acc_write && ({1'b0, wr_addr} < DEPTH_A)) begin
			mem[wr_addr[MEM_AW-1:0]] <= split_planes(wr_px);
		end
		if (acc_tick) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			ev_q   <= '0;
			seq_q  <= '0;
		end else if (acc_tick) begin
			if (line_q >= FINAL_L) begin
				line_q <= '0;
				ev_q   <= '0;
				seq_q  <= (seq_q == SEQ_LAST) ? '0 : seq_q + 1'b1;
			end else if (ev_q >= SHIFTS_E) begin
				line_q <= line_q + 1'b1;
				ev_q   <= '0;
			end else begin
				ev_q <= ev_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= acc_tick;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_tick) begin
			meta_s1 <= meta_d;
		end
	end

	always_comb begin
		case (meta_s1.plane)
			2'd0:    plane_byte = rdata_s1[31:24];
			2'd1:    plane_byte = rdata_s1[23:16];
			2'd2:    plane_byte = rdata_s1[15:8];
			2'd3:    plane_byte = rdata_s1[7:0];
			default: plane_byte = rdata_s1[31:24];
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			meta_s2 <= meta_s1;
			if (meta_s1.latch) begin
				nib_s2 <= 4'd0;
			end else begin
				nib_s2 <= meta_s1.sel_low ? plane_byte[3:0] : plane_byte[7:4];
			end
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {1'b0, meta_s2.plane, meta_s2.fr, nib_s2};
	assign m_axis_tuser  = meta_s2.latch;
	assign m_axis_tlast  = meta_s2.last;

	`SLGSC_ASSERT_IMPL(a_last_is_latch, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
	`SLGSC_ASSERT_IMPL(a_latch_zero_data, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[3:0] == 4'd0)
	`SLGSC_ASSERT_IMPL(a_final_line_empty, clk, arst_n, line_q == FINAL_L, ev_q == '0)
	`SLGSC_ASSERT_NEXT(a_frame_wraps, clk, arst_n, acc_tick && (line_q == FINAL_L), line_q == '0)

endmodule

/* tb/slgsc_event_checker.sv */
// ----------------------------------------------------------------------------
// STN LCD grayscale scan controller - panel event checker
// Watches both streams. Keeps a bit-plane image and scan counters of its own,
// predicts the panel event of every tick transaction, and compares each
// output transaction with the oldest prediction, one field at a time.
// ----------------------------------------------------------------------------
module slgsc_event_checker
	import slgsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// [13:0] column_address, [45:14] packed_pixels, [47:46] zero
	input  logic [47:0] s_axis_tdata,
	// [0] kind
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] data_nibble, [4] frame_signal, [6:5] plane_shown, [7] zero
	input  logic [7:0]  m_axis_tdata,
	// [0] is_latch
	input  logic        m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatch_count,
	output int          pending_events
);

	localparam int FRC_LEN = 15;

	// Frame rate control: MSB plane in 8 of the 15 frames, LSB plane once
	localparam logic [1:0] FRC_ORDER [FRC_LEN] = '{
		2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd0, 2'd1,
		2'd0, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0
	};

	typedef struct packed {
		logic [3:0] nibble;
		logic       fr;
		logic [1:0] plane;
		logic       latch;
		logic       last;
	} panel_event_t;

	logic [31:0]  bitplane_mem [STORE_DEPTH];
	logic [8:0]   line_idx;
	logic [6:0]   shift_idx;
	logic [3:0]   frc_idx;
	panel_event_t expected_events [$];
	int           err_count;
	int           event_count;

	// Eight pixels, MSB first; plane k gathers bit 3-k of every pixel into one byte
	function automatic logic [31:0] to_bitplanes(input logic [31:0] px);
		logic [31:0] word;
		logic [3:0]  nib;
		word = '0;
		for (int p = 0; p < 8; p++) begin
			nib = px[31 - 4 * p -: 4];
			for (int k = 0; k < 4; k++)
				word[31 - 8 * k - p] = nib[3 - k];
		end
		return word;
	endfunction

	function automatic logic [7:0] plane_row_byte(input int addr, input logic [1:0] plane);
		logic [31:0] word;
		word = bitplane_mem[addr];
		return word[31 - 8 * plane -: 8];
	endfunction

	task automatic predict_tick();
		panel_event_t ev;
		logic [7:0]   b;
		int           col;
		ev = '0;
		if (frc_idx >= FRC_LEN)
			frc_idx = '0;
		ev.plane = FRC_ORDER[frc_idx];
		ev.fr    = (line_idx == 0);
		if (line_idx >= FINAL_LINE) begin
			// closing latch of the frame
			ev.latch  = 1'b1;
			ev.last   = 1'b1;
			line_idx  = '0;
			shift_idx = '0;
			frc_idx   = (frc_idx == FRC_LEN - 1) ? 4'd0 : frc_idx + 4'd1;
		end else if (shift_idx >= SHIFTS) begin
			ev.latch  = 1'b1;
			line_idx  = line_idx + 9'd1;
			shift_idx = '0;
		end else begin
			col = int'(shift_idx) >> 1;
			if (line_idx < ROWS) begin
				b = plane_row_byte(int'(line_idx) * LINE_BYTES + col, ev.plane);
				ev.nibble = shift_idx[0] ? b[3:0] : b[7:4];
			end else begin
				// dummy lines repeat the high nibbles of the last row
				b = plane_row_byte((ROWS - 1) * LINE_BYTES + col, ev.plane);
				ev.nibble = b[7:4];
			end
			shift_idx = shift_idx + 7'd1;
		end
		expected_events.push_back(ev);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got_v,
		input logic [7:0] want_v);
		$display("ERROR: panel event %0d: %s is %0h, expected %0h",
			event_count, what, got_v, want_v);
		err_count++;
	endtask

	task automatic check_event();
		panel_event_t want;
		panel_event_t got;
		got.nibble = m_axis_tdata[3:0];
		got.fr     = m_axis_tdata[4];
		got.plane  = m_axis_tdata[6:5];
		got.latch  = m_axis_tuser;
		got.last   = m_axis_tlast;
		if (expected_events.size() == 0) begin
			report_mismatch("transaction with nothing pending, tdata", m_axis_tdata, 8'h00);
		end else begin
			want = expected_events.pop_front();
			if (got.nibble !== want.nibble)
				report_mismatch("data_nibble", 8'(got.nibble), 8'(want.nibble));
			if (got.fr !== want.fr)
				report_mismatch("frame_signal", 8'(got.fr), 8'(want.fr));
			if (got.plane !== want.plane)
				report_mismatch("plane_shown", 8'(got.plane), 8'(want.plane));
			if (got.latch !== want.latch)
				report_mismatch("is_latch", 8'(got.latch), 8'(want.latch));
			if (got.last !== want.last)
				report_mismatch("frame_last", 8'(got.last), 8'(want.last));
			if (m_axis_tdata[7] !== 1'b0)
				report_mismatch("tdata pad bit", 8'(m_axis_tdata[7]), 8'h00);
		end
		event_count++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			line_idx  = '0;
			shift_idx = '0;
			frc_idx   = '0;
			expected_events.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == KIND_TICK)
					predict_tick();
				else if (s_axis_tdata[13:0] < STORE_DEPTH)
					bitplane_mem[s_axis_tdata[13:0]] = to_bitplanes(s_axis_tdata[45:14]);
			end
			if (m_axis_tvalid && m_axis_tready)
				check_event();
		end
		pending_events <= expected_events.size();
		mismatch_count <= err_count;
	end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// STN LCD grayscale scan controller - testbench top
// Loads the image rows that the ticks can reach, runs a short directed
// sequence, then random runs of ticks and writes over several idle and stall
// settings. A checker module does the compare.
// ----------------------------------------------------------------------------
module tb;
	import slgsc_pkg::*;

	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 20_000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_ADDR     = 2 ** ADDR_W - 1;
	localparam int N_PHASES     = 4;

	// Ticks stay well inside these rows, so no unloaded entry is ever scanned
	localparam int PRELOAD_ROWS = 6;

	localparam int PHASE_ITEMS    [N_PHASES] = '{90, 90, 90, 90};
	localparam int SEND_IDLE_PCT  [N_PHASES] = '{0, 63, 0, 16};
	localparam int RECV_STALL_PCT [N_PHASES] = '{0, 0, 63, 16};
	localparam int WRITE_PCT      [N_PHASES] = '{6, 25, 25, 25};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	int          mismatch_count;
	int          pending_events;
	int          send_idle_pct;
	int          recv_stall_pct;

	always #2 clk = ~clk;

	stn_lcd_grayscale_scan_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	slgsc_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.pending_events (pending_events)
	);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic logic [31:0] random_pixels();
		case ($urandom_range(7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Some writes miss the store, many land on the row the dummy lines repeat
	function automatic logic [13:0] random_write_addr();
		case ($urandom_range(7))
			0:       return 14'($urandom_range(MAX_ADDR, STORE_DEPTH));
			1, 2:    return 14'((ROWS - 1) * LINE_BYTES + $urandom_range(LINE_BYTES - 1));
			default: return 14'($urandom_range(STORE_DEPTH - 1));
		endcase
	endfunction

	task automatic send_item(input logic kind, input logic [13:0] addr, input logic [31:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, px, addr};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Address and pixel fields are don't-care on ticks; fill them with noise
	task automatic send_tick();
		send_item(KIND_TICK, 14'($urandom), $urandom);
	endtask

	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = KIND_WRITE;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// rows the scan will reach go in before the first tick
		for (int a = 0; a < PRELOAD_ROWS * LINE_BYTES; a++)
			send_item(KIND_WRITE, 14'(a), random_pixels());

		send_item(KIND_WRITE, 14'(STORE_DEPTH), 32'hFFFF_FFFF);
		send_item(KIND_WRITE, 14'(MAX_ADDR), 32'hFFFF_FFFF);
		send_item(KIND_WRITE, 14'd0, 32'h0123_4567);
		send_tick();
		// rewrite mid-line: the low nibble shift must see the new data
		send_item(KIND_WRITE, 14'd0, 32'h89AB_CDEF);
		send_tick();
		send_item(KIND_WRITE, 14'd1, 32'hFFFF_FFFF);
		send_tick();
		send_tick();
		send_item(KIND_WRITE, 14'd2, 32'h0000_0000);
		send_tick();
		send_tick();
		send_item(KIND_WRITE, 14'd3, 32'h8421_1248);
		send_tick();
		send_tick();
		send_item(KIND_WRITE, 14'(STORE_DEPTH - 1), 32'hF0F0_0F0F);
		send_item(KIND_WRITE, 14'((ROWS - 1) * LINE_BYTES), 32'h7E5A_A5E7);
		send_tick();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			send_idle_pct  = SEND_IDLE_PCT[ph];
			recv_stall_pct <= RECV_STALL_PCT[ph];
			for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
				if ($urandom_range(99) < WRITE_PCT[ph])
					send_item(KIND_WRITE, random_write_addr(), random_pixels());
				else
					send_tick();
			end
			drain_pause();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		for (int cycle = 0; cycle < CYCLE_LIMIT; cycle++)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/slgsc_pkg.sv
hw/rtl/stn_lcd_grayscale_scan_controller.sv
tb/slgsc_event_checker.sv
tb/tb.sv
